// File: rtl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
// No dependencies; imported by every module of the block.
package qvr_pkg;

   // Quaternion components are signed Q2.14.
   localparam int QUAT_W = 16;
   localparam int PROD_W = 2 * QUAT_W;
   // Matrix entries are sums of up to four products, doubled on the off-diagonal.
   localparam int MAT_W = PROD_W + 2;
   // Matrix entries are split in two halves so that each multiplier stays narrow.
   localparam int MLO_W = MAT_W / 2;
   localparam int MHI_W = MAT_W - MLO_W;
   // A product of two Q2.14 values carries a scale of 2^28.
   localparam int FRAC_SHIFT = 2 * (QUAT_W - 2);
   // Growth of a row sum over the vector width.
   localparam int SUM_GROW = MHI_W + MLO_W + 3;
   localparam int MAT_ENTRIES = 9;

   typedef logic signed [QUAT_W-1:0] quat_comp_type;

   typedef struct packed {
      quat_comp_type w;
      quat_comp_type z;
      quat_comp_type y;
      quat_comp_type x;
   } quat_type;

   // Row-major 3x3 matrix, entry r*3+c.
   typedef logic [MAT_ENTRIES-1:0][MAT_W-1:0] mat_type;

endpackage

// File: rtl/quaternion_vector_rotate.sv
// Quaternion vector rotation: returns the vector part of q*v*conj(q), rounded and saturated.
// Throughput is one item per cycle while the output is not stalled; each of the
// six stages advances on its own, so bubbles close up.
// Reset clears only the stage valid bits; no other state is held.
// Depends on qvr_pkg, qvr_matrix, qvr_mac and qvr_round.
module quaternion_vector_rotate #(
   parameter int  VECTOR_WIDTH = 16,
   localparam int REQ_W = ((4 * qvr_pkg::QUAT_W + 3 * VECTOR_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((3 * VECTOR_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, zero padding
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // rot_x, rot_y, rot_z, zero padding
   output logic [RSP_W-1:0] rsp_tdata,
   // saturated
   output logic             rsp_tuser
);
   import qvr_pkg::*;

   localparam int TOT_W = VECTOR_WIDTH + SUM_GROW;

   quat_type                     in_quat;
   logic [2:0][VECTOR_WIDTH-1:0] in_vec;
   logic                         mat_valid, mat_ready;
   mat_type                      mat;
   logic [2:0][VECTOR_WIDTH-1:0] mat_vec;
   logic                         sum_valid, sum_ready;
   logic [2:0][TOT_W-1:0]        sum;
   logic [2:0][VECTOR_WIDTH-1:0] rot;

   assign in_quat = req_tdata[4*QUAT_W-1:0];
   assign in_vec  = req_tdata[4*QUAT_W +: 3*VECTOR_WIDTH];

   qvr_matrix #(.VECTOR_WIDTH(VECTOR_WIDTH)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_quat   (in_quat),
      .in_vec    (in_vec),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_mat   (mat),
      .out_vec   (mat_vec)
   );

   qvr_mac #(.VECTOR_WIDTH(VECTOR_WIDTH)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_mat    (mat),
      .in_vec    (mat_vec),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum)
   );

   qvr_round #(.VECTOR_WIDTH(VECTOR_WIDTH)) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sum),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rot   (rot),
      .out_sat   (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(rot);

   // An empty or draining output stage lets every earlier stage move, so input is open.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("quaternion_vector_rotate: input blocked with an empty output stage");

   a_ready_when_draining: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("quaternion_vector_rotate: input blocked while the output drains");

endmodule

// File: rtl/qvr_matrix.sv
// Two pipeline stages: the ten quadratic terms of the quaternion, then the
// unnormalised rotation matrix. Depends on qvr_pkg.
module qvr_matrix #(
   parameter int VECTOR_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  qvr_pkg::quat_type              in_quat,
   input  logic [2:0][VECTOR_WIDTH-1:0]   in_vec,
   output logic                           out_valid,
   input  logic                           out_ready,
   output qvr_pkg::mat_type               out_mat,
   output logic [2:0][VECTOR_WIDTH-1:0]   out_vec
);
   import qvr_pkg::*;

   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic s1_en, s2_en;

   logic signed [PROD_W-1:0] xx_in, yy_in, zz_in, ww_in, xy_in;
   logic signed [PROD_W-1:0] xz_in, yz_in, wx_in, wy_in, wz_in;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff;
   logic signed [PROD_W-1:0] xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic [2:0][VECTOR_WIDTH-1:0] vec1_ff, vec2_ff;
   mat_type mat_in, mat_ff;

   function automatic logic signed [MAT_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      return MAT_W'(p);
   endfunction

   // Each stage moves on when it is empty or the stage after it moves on.
   assign s2_en    = !s2_valid_ff || out_ready;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   assign s1_valid_in = s1_en ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      xx_in = in_quat.x * in_quat.x;
      yy_in = in_quat.y * in_quat.y;
      zz_in = in_quat.z * in_quat.z;
      ww_in = in_quat.w * in_quat.w;
      xy_in = in_quat.x * in_quat.y;
      xz_in = in_quat.x * in_quat.z;
      yz_in = in_quat.y * in_quat.z;
      wx_in = in_quat.w * in_quat.x;
      wy_in = in_quat.w * in_quat.y;
      wz_in = in_quat.w * in_quat.z;
   end

   always_comb begin
      mat_in[0] = ext(ww_ff) + ext(xx_ff) - ext(yy_ff) - ext(zz_ff);
      mat_in[1] = (ext(xy_ff) - ext(wz_ff)) <<< 1;
      mat_in[2] = (ext(xz_ff) + ext(wy_ff)) <<< 1;
      mat_in[3] = (ext(xy_ff) + ext(wz_ff)) <<< 1;
      mat_in[4] = ext(ww_ff) - ext(xx_ff) + ext(yy_ff) - ext(zz_ff);
      mat_in[5] = (ext(yz_ff) - ext(wx_ff)) <<< 1;
      mat_in[6] = (ext(xz_ff) - ext(wy_ff)) <<< 1;
      mat_in[7] = (ext(yz_ff) + ext(wx_ff)) <<< 1;
      mat_in[8] = ext(ww_ff) - ext(xx_ff) - ext(yy_ff) + ext(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         xx_ff   <= xx_in;
         yy_ff   <= yy_in;
         zz_ff   <= zz_in;
         ww_ff   <= ww_in;
         xy_ff   <= xy_in;
         xz_ff   <= xz_in;
         yz_ff   <= yz_in;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         wz_ff   <= wz_in;
         vec1_ff <= in_vec;
      end
      if (s2_en) begin
         mat_ff  <= mat_in;
         vec2_ff <= vec1_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_mat   = mat_ff;
   assign out_vec   = vec2_ff;

endmodule

// File: rtl/qvr_mac.sv
// Three pipeline stages: split matrix-by-vector partial products, row sums of
// each half with the rounding offset, then the recombined exact row totals.
// Depends on qvr_pkg.
module qvr_mac #(
   parameter int VECTOR_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  qvr_pkg::mat_type                                  in_mat,
   input  logic [2:0][VECTOR_WIDTH-1:0]                      in_vec,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic [2:0][VECTOR_WIDTH+qvr_pkg::SUM_GROW-1:0]    out_sum
);
   import qvr_pkg::*;

   localparam int PH_W  = MHI_W + VECTOR_WIDTH;
   localparam int PL_W  = MLO_W + 1 + VECTOR_WIDTH;
   localparam int HS_W  = PH_W + 2;
   localparam int LS_W  = PL_W + 3;
   localparam int TOT_W = VECTOR_WIDTH + SUM_GROW;
   localparam logic signed [LS_W-1:0] ROUND_HALF = LS_W'(64'sd1 <<< (FRAC_SHIFT - 1));

   logic s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s3_en, s4_en, s5_en;

   logic signed [PH_W-1:0]  ph_in [MAT_ENTRIES];
   logic signed [PH_W-1:0]  ph_ff [MAT_ENTRIES];
   logic signed [PL_W-1:0]  pl_in [MAT_ENTRIES];
   logic signed [PL_W-1:0]  pl_ff [MAT_ENTRIES];
   logic signed [HS_W-1:0]  hs_in [3];
   logic signed [HS_W-1:0]  hs_ff [3];
   logic signed [LS_W-1:0]  ls_in [3];
   logic signed [LS_W-1:0]  ls_ff [3];
   logic [2:0][TOT_W-1:0]   tot_in, tot_ff;

   assign s5_en    = !s5_valid_ff || out_ready;
   assign s4_en    = !s4_valid_ff || s5_en;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign in_ready = s3_en;

   // Each entry m = m_hi * 2^17 + m_lo, with m_lo taken as unsigned.
   always_comb begin
      logic signed [MHI_W-1:0]        m_hi;
      logic signed [MLO_W:0]          m_lo;
      logic signed [VECTOR_WIDTH-1:0] v;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            m_hi = $signed(in_mat[r*3+c][MAT_W-1:MLO_W]);
            m_lo = $signed({1'b0, in_mat[r*3+c][MLO_W-1:0]});
            v    = $signed(in_vec[c]);
            ph_in[r*3+c] = m_hi * v;
            pl_in[r*3+c] = m_lo * v;
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         hs_in[r] = HS_W'(ph_ff[r*3]) + HS_W'(ph_ff[r*3+1]) + HS_W'(ph_ff[r*3+2]);
         ls_in[r] = LS_W'(pl_ff[r*3]) + LS_W'(pl_ff[r*3+1]) + LS_W'(pl_ff[r*3+2])
                    + ROUND_HALF;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         tot_in[r] = (TOT_W'(hs_ff[r]) <<< MLO_W) + TOT_W'(ls_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s3_en) begin
            s3_valid_ff <= in_valid;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_en) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      if (s4_en) begin
         hs_ff <= hs_in;
         ls_ff <= ls_in;
      end
      if (s5_en) begin
         tot_ff <= tot_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_sum   = tot_ff;

   // A stalled stage must keep its item.
   a_s5_hold: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && !out_ready) |=> s5_valid_ff)
      else $error("qvr_mac: last stage dropped a stalled item");

endmodule

// File: rtl/qvr_round.sv
// Output stage: drops the 2^28 scale (rounding offset already added),
// saturates each component and raises the clip flag. Depends on qvr_pkg.
module qvr_round #(
   parameter int VECTOR_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [2:0][VECTOR_WIDTH+qvr_pkg::SUM_GROW-1:0]    in_sum,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic [2:0][VECTOR_WIDTH-1:0]                      out_rot,
   output logic                                              out_sat
);
   import qvr_pkg::*;

   localparam int TOT_W = VECTOR_WIDTH + SUM_GROW;
   localparam int Q_W   = TOT_W - FRAC_SHIFT;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (VECTOR_WIDTH - 1)) - 64'sd1);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);
   localparam logic [VECTOR_WIDTH-1:0] ROT_MAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
   localparam logic [VECTOR_WIDTH-1:0] ROT_MIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

   logic                          valid_ff, stage_en;
   logic signed [TOT_W-1:0]       shifted [3];
   logic signed [Q_W-1:0]         q [3];
   logic [2:0][VECTOR_WIDTH-1:0]  rot_in, rot_ff;
   logic                          sat_in, sat_ff;

   assign stage_en = !valid_ff || out_ready;
   assign in_ready = stage_en;

   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         shifted[r] = $signed(in_sum[r]) >>> FRAC_SHIFT;
         q[r]       = shifted[r][Q_W-1:0];
         if (q[r] > Q_MAX) begin
            rot_in[r] = ROT_MAX;
            sat_in    = 1'b1;
         end else if (q[r] < Q_MIN) begin
            rot_in[r] = ROT_MIN;
            sat_in    = 1'b1;
         end else begin
            rot_in[r] = q[r][VECTOR_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_sat   = sat_ff;

   // A flagged item must have at least one component pinned at a limit.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && sat_ff) |->
         (rot_ff[0] == ROT_MAX || rot_ff[0] == ROT_MIN ||
          rot_ff[1] == ROT_MAX || rot_ff[1] == ROT_MIN ||
          rot_ff[2] == ROT_MAX || rot_ff[2] == ROT_MIN))
      else $error("qvr_round: clip flag set with no component at a limit");

endmodule

// File: tb/sv/tb_quaternion_vector_rotate.sv
// Self-checking testbench for quaternion_vector_rotate: directed table, then random items.
// Expected rotations come from a fixed-point predictor kept in this file; needs qvr_pkg and the RTL.
module tb_quaternion_vector_rotate;
   import qvr_pkg::*;

   localparam int VEC_W = 16;
   localparam int REQ_W = ((4 * QUAT_W + 3 * VEC_W + 7) / 8) * 8;
   localparam int RSP_W = ((3 * VEC_W + 7) / 8) * 8;
   localparam longint VEC_MAX = (64'sd1 <<< (VEC_W - 1)) - 1;
   localparam longint VEC_MIN = -(64'sd1 <<< (VEC_W - 1));
   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int LONG_HOLD = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int RUN_LIMIT = 2_000_000;

   typedef struct packed {
      logic signed [VEC_W-1:0] vec_z;
      logic signed [VEC_W-1:0] vec_y;
      logic signed [VEC_W-1:0] vec_x;
      quat_type                quat;
   } rotate_req_type;

   typedef struct packed {
      logic                    saturated;
      logic signed [VEC_W-1:0] rot_z;
      logic signed [VEC_W-1:0] rot_y;
      logic signed [VEC_W-1:0] rot_x;
   } rotation_type;

   typedef struct {
      int qx, qy, qz, qw, vx, vy, vz;
      bit known;
      int ex, ey, ez;
      bit esat;
   } rotate_case_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // rot_x, rot_y, rot_z
   logic [RSP_W-1:0] rsp_tdata;
   // saturated
   logic             rsp_tuser;

   rotation_type pending_rotations[$];
   rotation_type offered_rotation;
   int           mismatches = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;
   int           hold_requests = 0;
   int           holds_done = 0;
   int           hold_left = 0;

   // Rows marked known carry a result that can be worked out by hand; the rest are predicted.
   rotate_case_type directed_cases [DIRECTED_ROWS] = '{
      '{0, 0, 0, 0, 1234, -32768, 32767, 1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
      '{0, 0, 0, 16384, 32767, -32768, -1, 1, 32767, -32768, -1, 0},
      '{0, 0, 0, 16384, 0, 1, -1, 1, 0, 1, -1, 0},
      '{0, 0, 0, -16384, -32768, 32767, 100, 1, -32768, 32767, 100, 0},
      '{0, 0, 0, 8192, 2, -2, 6, 1, 1, 0, 2, 0},
      '{0, 0, 0, 8192, -6, 1, 3, 1, -1, 0, 1, 0},
      '{0, 0, 0, -32768, 1, -1, 0, 1, 4, -4, 0, 0},
      '{0, 0, 0, -32768, 32767, -32768, 8192, 1, 32767, -32768, 32767, 1},
      '{16384, 0, 0, 0, 100, -32768, 5, 1, 100, 32767, -5, 1},
      '{0, 16384, 0, 0, 7, -8, 9, 1, -7, -8, -9, 0},
      '{0, 0, 16384, 0, 7, -8, 9, 1, -7, 8, 9, 0},
      '{0, 0, -32768, 0, 1, 2, 3, 1, -4, -8, 12, 0},
      '{-32768, 0, 0, 0, -32768, 0, 0, 1, -32768, 0, 0, 1},
      '{0, 0, 11585, 11585, 1000, 2000, -3000, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0, 0},
      '{21845, -21846, 21845, -21846, 21845, -21846, 21845, 0, 0, 0, 0, 0},
      '{-21846, 21845, -21846, 21845, -21846, 21845, -21846, 0, 0, 0, 0, 0},
      '{4096, -8192, 12288, -2048, -12345, 23456, -77, 0, 0, 0, 0, 0}
   };

   quaternion_vector_rotate #(
      .VECTOR_WIDTH(VEC_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #4 clock = ~clock;

   // The exact product q*v*conj(q) carries a scale of 2^28; round half up, then clip.
   function automatic rotation_type rotate_vector(input rotate_req_type item);
      longint qx, qy, qz, qw, acc, rounded;
      longint mat [3][3];
      longint vec [3];
      logic signed [VEC_W-1:0] rotated [3];
      rotation_type res;
      qx = item.quat.x;
      qy = item.quat.y;
      qz = item.quat.z;
      qw = item.quat.w;
      vec[0] = item.vec_x;
      vec[1] = item.vec_y;
      vec[2] = item.vec_z;
      mat[0][0] = qw * qw + qx * qx - qy * qy - qz * qz;
      mat[0][1] = 2 * (qx * qy - qw * qz);
      mat[0][2] = 2 * (qx * qz + qw * qy);
      mat[1][0] = 2 * (qx * qy + qw * qz);
      mat[1][1] = qw * qw - qx * qx + qy * qy - qz * qz;
      mat[1][2] = 2 * (qy * qz - qw * qx);
      mat[2][0] = 2 * (qx * qz - qw * qy);
      mat[2][1] = 2 * (qy * qz + qw * qx);
      mat[2][2] = qw * qw - qx * qx - qy * qy + qz * qz;
      res.saturated = 1'b0;
      for (int r = 0; r < 3; r++) begin
         acc = mat[r][0] * vec[0] + mat[r][1] * vec[1] + mat[r][2] * vec[2];
         rounded = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
         if (rounded > VEC_MAX) begin
            rounded = VEC_MAX;
            res.saturated = 1'b1;
         end else if (rounded < VEC_MIN) begin
            rounded = VEC_MIN;
            res.saturated = 1'b1;
         end
         rotated[r] = VEC_W'(rounded);
      end
      res.rot_x = rotated[0];
      res.rot_y = rotated[1];
      res.rot_z = rotated[2];
      return res;
   endfunction

   function automatic logic [15:0] corner_value();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mix of fully random items, quaternions with each component within +-0.5, short vectors and corner values.
   function automatic rotate_req_type random_request();
      rotate_req_type item;
      item.quat.x = 16'($urandom);
      item.quat.y = 16'($urandom);
      item.quat.z = 16'($urandom);
      item.quat.w = 16'($urandom);
      item.vec_x = VEC_W'($urandom);
      item.vec_y = VEC_W'($urandom);
      item.vec_z = VEC_W'($urandom);
      case ($urandom_range(3))
         1: begin
            item.quat.x = 16'(int'($urandom_range(16384)) - 8192);
            item.quat.y = 16'(int'($urandom_range(16384)) - 8192);
            item.quat.z = 16'(int'($urandom_range(16384)) - 8192);
            item.quat.w = 16'(int'($urandom_range(16384)) - 8192);
         end
         2: begin
            item.vec_x = VEC_W'(int'($urandom_range(128)) - 64);
            item.vec_y = VEC_W'(int'($urandom_range(128)) - 64);
            item.vec_z = VEC_W'(int'($urandom_range(128)) - 64);
         end
         3: begin
            item.quat.x = corner_value();
            item.quat.y = corner_value();
            item.quat.z = corner_value();
            item.quat.w = corner_value();
            item.vec_x = corner_value();
            item.vec_y = corner_value();
            item.vec_z = corner_value();
         end
         default: ;
      endcase
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer_item(input rotate_req_type item, input rotation_type expected);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item;
      offered_rotation = expected;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input int wanted, input int actual);
      if (wanted != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, wanted, actual);
         mismatches++;
      end
   endtask

   // The receiver serves a long hold-off whenever the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done = holds_done + 1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      rotation_type actual;
      rotation_type wanted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            actual = {rsp_tuser, rsp_tdata};
            if (pending_rotations.size() == 0) begin
               $error("result item arrived with no item outstanding");
               mismatches++;
            end else begin
               wanted = pending_rotations.pop_front();
               check_field("rot_x", wanted.rot_x, actual.rot_x);
               check_field("rot_y", wanted.rot_y, actual.rot_y);
               check_field("rot_z", wanted.rot_z, actual.rot_z);
               check_field("saturated", wanted.saturated, actual.saturated);
            end
         end
         if (req_tvalid && req_tready)
            pending_rotations.push_back(offered_rotation);
      end
   end

   initial begin
      #RUN_LIMIT;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      rotate_req_type item;
      rotation_type expected;
      rotate_case_type row;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_cases[i];
         item.quat.x = 16'(row.qx);
         item.quat.y = 16'(row.qy);
         item.quat.z = 16'(row.qz);
         item.quat.w = 16'(row.qw);
         item.vec_x = VEC_W'(row.vx);
         item.vec_y = VEC_W'(row.vy);
         item.vec_z = VEC_W'(row.vz);
         if (row.known) begin
            expected.rot_x = VEC_W'(row.ex);
            expected.rot_y = VEC_W'(row.ey);
            expected.rot_z = VEC_W'(row.ez);
            expected.saturated = row.esat;
         end else begin
            expected = rotate_vector(item);
         end
         offer_item(item, expected);
      end

      // Phases: no idling, sender idle, receiver stalling, both idling a little.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               sender_idle_pct = 82;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 82;
            end
            3: begin
               sender_idle_pct = 13;
               receiver_stall_pct = 13;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // A long hold-off while items keep coming fills the pipeline.
            if (phase == 0 && n == 100)
               hold_requests++;
            item = random_request();
            offer_item(item, rotate_vector(item));
         end
         // Pause until every outstanding item has come back.
         req_tvalid <= 1'b0;
         while (pending_rotations.size() != 0) @(posedge clock);
         @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rotations.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
rtl/qvr_pkg.sv
rtl/qvr_matrix.sv
rtl/qvr_mac.sv
rtl/qvr_round.sv
rtl/quaternion_vector_rotate.sv
tb/sv/tb_quaternion_vector_rotate.sv
